FILE: rtl/csd_pkg.sv
// Shared types, widths and codes for the character sequence delete block.
// Used by csd_dp, csd_ctrl and the top level under rtl; no dependencies.
package csd_pkg;

  localparam int CAPACITY    = 64;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMD_W       = 3;
  localparam int CHAR_W      = 8;
  localparam int RIDX_W      = 6;
  localparam int ST_W        = 2;
  localparam int LEN_W       = 7;
  localparam int CMP_W       = (RIDX_W > CNT_W) ? RIDX_W : CNT_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_ALL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic scan_start;
    logic scan_run;
    logic find;
    logic pack_finish;
    logic rd_capture;
    logic load_out;
  } csd_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             scan_done;
    logic             out_free;
  } csd_sts_t;

endpackage

FILE: rtl/csd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/csd_dp.sv
// Datapath: command latch, fill count, scan/compaction counters, result and output registers.
// Depends on csd_pkg and csd_ram.
module csd_dp
  import csd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  csd_cmd_t               ctl,
  output csd_sts_t               sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]      val_r, val_nxt;
  logic [RIDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       ra_r, ra_nxt;
  logic                   sv_r, sv_nxt;
  logic [IDX_W-1:0]       sidx_r, sidx_nxt;
  logic [CNT_W-1:0]       wp_r, wp_nxt;
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [ST_W-1:0]        st_r, st_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [CHAR_W-1:0]      rdc_r, rdc_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  fill_ext;
  logic              match;
  logic              drop;

  csd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign idx_ext  = CMP_W'(idx_r);
  assign fill_ext = CMP_W'(fill_r);
  assign match    = (rd_data == val_r);
  // entry leaves the sequence during compaction
  assign drop = ((cmd_r == CMD_DEL_ALL) && match) ||
                ((cmd_r == CMD_DEL_FIRST) && match && !hit_r) ||
                ((cmd_r == CMD_DEL_LAST) && hit_r && (sidx_r == pos_r));

  always_comb begin
    cmd_nxt      = cmd_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    fill_nxt     = fill_r;
    ra_nxt       = ra_r;
    sv_nxt       = sv_r;
    sidx_nxt     = sidx_r;
    wp_nxt       = wp_r;
    hit_nxt      = hit_r;
    pos_nxt      = pos_r;
    st_nxt       = st_r;
    rem_nxt      = rem_r;
    rdc_nxt      = rdc_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    wr_en        = 1'b0;
    wr_addr      = wp_r[IDX_W-1:0];
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = ra_r[IDX_W-1:0];

    if (ctl.accept) begin
      cmd_nxt = in_tdata[CMD_W-1:0];
      val_nxt = in_tdata[CMD_W +: CHAR_W];
      idx_nxt = in_tdata[CMD_W + CHAR_W +: RIDX_W];
      st_nxt  = ST_OK;
      rem_nxt = '0;
      rdc_nxt = '0;
      hit_nxt = 1'b0;
    end

    if (ctl.dispatch) begin
      case (cmd_r)
        CMD_APPEND: begin
          if (fill_r >= CNT_W'(CAPACITY)) begin
            st_nxt = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = fill_r[IDX_W-1:0];
            wr_data  = val_r;
            fill_nxt = fill_r + 1'b1;
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_ALL: begin
          if (fill_r == '0) begin
            st_nxt = ST_UNDERFLOW;
          end
        end
        CMD_READ: begin
          if (idx_ext < fill_ext) begin
            rd_en   = 1'b1;
            rd_addr = idx_ext[IDX_W-1:0];
          end else begin
            st_nxt = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl.scan_run) begin
      // issue the next read while entries remain
      if (ra_r < fill_r) begin
        rd_en    = 1'b1;
        ra_nxt   = ra_r + 1'b1;
        sv_nxt   = 1'b1;
        sidx_nxt = ra_r[IDX_W-1:0];
      end else begin
        sv_nxt = 1'b0;
      end
      // handle the entry read in the previous cycle
      if (sv_r) begin
        if (ctl.find) begin
          if (match) begin
            hit_nxt = 1'b1;
            pos_nxt = sidx_r;
          end
        end else begin
          if ((cmd_r == CMD_DEL_FIRST) && match) begin
            hit_nxt = 1'b1;
          end
          if (!drop) begin
            wr_en  = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
        end
      end
    end

    if (ctl.scan_start) begin
      ra_nxt = '0;
      sv_nxt = 1'b0;
      wp_nxt = '0;
    end

    if (ctl.pack_finish) begin
      fill_nxt = wp_r;
      rem_nxt  = LEN_W'(fill_r - wp_r);
    end

    if (ctl.rd_capture) begin
      rdc_nxt = (st_r == ST_OK) ? rd_data : '0;
    end

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (ctl.load_out) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = {rdc_r, rem_r, LEN_W'(fill_r), st_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      ra_r      <= '0;
      sv_r      <= 1'b0;
      wp_r      <= '0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      ra_r      <= ra_nxt;
      sv_r      <= sv_nxt;
      wp_r      <= wp_nxt;
      hit_r     <= hit_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    sidx_r     <= sidx_nxt;
    pos_r      <= pos_nxt;
    st_r       <= st_nxt;
    rem_r      <= rem_nxt;
    rdc_r      <= rdc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.cmd       = cmd_r;
  assign sts.empty     = (fill_r == '0);
  assign sts.scan_done = (ra_r == fill_r) && !sv_r;
  assign sts.out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_wp_behind_ra: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= ra_r)
    else $error("compaction write pointer ahead of read pointer");

  a_pack_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scan_run && !ctl.find && sv_r && !drop) |-> (wp_r <= CNT_W'(sidx_r)))
    else $error("compaction write overtakes the entry just read");

  a_single_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_out && ((cmd_r == CMD_DEL_FIRST) || (cmd_r == CMD_DEL_LAST)))
      |-> (rem_r <= LEN_W'(1)))
    else $error("single delete removed more than one entry");

endmodule

FILE: rtl/csd_ctrl.sv
// Controller state machine: sequences dispatch, search, compaction and result hand-off.
// Depends on csd_pkg.
module csd_ctrl
  import csd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  csd_sts_t sts,
  output csd_cmd_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_FIND = 6'b000100,
    S_PACK = 6'b001000,
    S_RDW  = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        ctl.dispatch = 1'b1;
        case (sts.cmd)
          CMD_DEL_FIRST, CMD_DEL_ALL: begin
            if (sts.empty) begin
              state_nxt = S_RES;
            end else begin
              ctl.scan_start = 1'b1;
              state_nxt      = S_PACK;
            end
          end
          CMD_DEL_LAST: begin
            if (sts.empty) begin
              state_nxt = S_RES;
            end else begin
              ctl.scan_start = 1'b1;
              state_nxt      = S_FIND;
            end
          end
          CMD_READ: state_nxt = S_RDW;
          default:  state_nxt = S_RES;
        endcase
      end
      S_FIND: begin
        ctl.scan_run = 1'b1;
        ctl.find     = 1'b1;
        if (sts.scan_done) begin
          ctl.scan_start = 1'b1;
          state_nxt      = S_PACK;
        end
      end
      S_PACK: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_done) begin
          ctl.pack_finish = 1'b1;
          state_nxt       = S_RES;
        end
      end
      S_RDW: begin
        ctl.rd_capture = 1'b1;
        state_nxt      = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/char_sequence_delete_by_value_core.sv
// Ordered byte sequence store with delete-by-value: top level joining controller and datapath.
// Depends on csd_pkg, csd_ctrl, csd_dp (and csd_ram through csd_dp).
//
// Keeps up to CAPACITY (64) characters in order in a simple dual-port RAM and
// answers each command item with exactly one result item. Commands: append,
// delete first / last / every occurrence of a character (the gap is closed and
// order kept), and read the entry at an index. One item is worked on at a time;
// a new item is taken once the previous one has finished its work, even while
// its result still waits in the output register. Deletes are bounded by the
// single RAM read port, which scans one entry per cycle while the compacted
// entries are written back behind it; delete last first scans for the last
// match, then compacts. No clearing pass is needed after reset: only entries
// below the fill count are ever read.
module char_sequence_delete_by_value_core
  import csd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [10:3] char_value, [16:11] read_index, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [8:2] length, [15:9] removed_count, [23:16] read_char
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  csd_cmd_t ctl;
  csd_sts_t sts;

  // Sequence the work of each item
  csd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Hold the store, counters and the output register
  csd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: bench/char_sequence_delete_by_value_core_tb.sv
// Self-checking bench for char_sequence_delete_by_value_core: directed and random commands
// with a scoreboard class that mirrors the ordered character store.
// Depends on csd_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module char_sequence_delete_by_value_core_tb;
  import csd_pkg::*;

  // Commands the block treats as no operation
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1280;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 200;   // longest delete is delete last, which scans twice
  localparam int HOLD_AT      = 250;   // command count that triggers the long stall
  localparam int HOLD_CYCLES  = 500;
  localparam int QUIET_FROM   = 500;
  localparam int QUIET_TO     = 700;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} cmd_mix_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  removed;
    logic [CHAR_W-1:0] read_char;
  } seq_result_t;

  // Mirror of the character store; predicts one result per accepted command.
  class char_seq_scoreboard;
    logic [CHAR_W-1:0] chars [CAPACITY];
    int unsigned       fill;
    seq_result_t       expected_q[$];
    int                errors;

    function void clear();
      fill = 0;
      errors = 0;
      expected_q.delete();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void remove_at(int unsigned pos);
      for (int unsigned j = pos; j + 1 < fill; j++) chars[j] = chars[j + 1];
      fill--;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] val,
                               logic [RIDX_W-1:0] idx);
      seq_result_t  res;
      int           pos;
      int unsigned  keep;
      int unsigned  before_fill;
      res.status    = ST_OK;
      res.removed   = '0;
      res.read_char = '0;
      case (cmd)
        CMD_APPEND: begin
          if (fill >= CAPACITY) res.status = ST_FULL;
          else begin
            chars[fill] = val;
            fill++;
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST: begin
          if (fill == 0) res.status = ST_UNDERFLOW;
          else begin
            pos = -1;
            for (int i = 0; i < int'(fill); i++) begin
              if (chars[i] == val && (cmd == CMD_DEL_LAST || pos < 0)) pos = i;
            end
            if (pos >= 0) begin
              remove_at(pos);
              res.removed = 1;
            end
          end
        end
        CMD_DEL_ALL: begin
          if (fill == 0) res.status = ST_UNDERFLOW;
          else begin
            // pack the survivors to the front, keeping their order
            keep = 0;
            before_fill = fill;
            for (int unsigned i = 0; i < before_fill; i++) begin
              if (chars[i] != val) begin
                chars[keep] = chars[i];
                keep++;
              end
            end
            res.removed = LEN_W'(before_fill - keep);
            fill = keep;
          end
        end
        CMD_READ: begin
          if (idx < fill) res.read_char = chars[idx];
          else res.status = ST_RANGE;
        end
        default: ;
      endcase
      res.length = LEN_W'(fill);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      seq_result_t want;
      seq_result_t got;
      got.status    = tdata[1:0];
      got.length    = tdata[8:2];
      got.removed   = tdata[15:9];
      got.read_char = tdata[23:16];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result item, expected none, actual tdata %h",
                 $time, tdata);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t ns: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.length !== want.length) begin
        errors++;
        $display("%0t ns: length mismatch, expected %0d, actual %0d",
                 $time, want.length, got.length);
      end
      if (got.removed !== want.removed) begin
        errors++;
        $display("%0t ns: removed_count mismatch, expected %0d, actual %0d",
                 $time, want.removed, got.removed);
      end
      if (got.read_char !== want.read_char) begin
        errors++;
        $display("%0t ns: read_char mismatch, expected %h, actual %h",
                 $time, want.read_char, got.read_char);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [2:0] cmd, [10:3] char_value, [16:11] read_index
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [1:0] status, [8:2] length, [15:9] removed, [23:16] read_char

  char_seq_scoreboard sb;
  int                 accepted_cmds;
  int                 cycle_count;
  int                 hold_left;
  bit                 hold_done;

  char_sequence_delete_by_value_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Quiet stretch: neither side idles while this is set
  function automatic bit quiet_now();
    return accepted_cmds >= QUIET_FROM && accepted_cmds < QUIET_TO;
  endfunction

  function automatic logic [CMD_W-1:0] CMD_WIDTH_CAST(int unsigned v);
    return v[CMD_W-1:0];
  endfunction

  // Hard stop on a hang; the slowest correct run is far below the limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every result item accepted at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random back-pressure, one long hold-off so the block fills and stalls its input
  always @(negedge clk) begin
    if (!hold_done && accepted_cmds >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (quiet_now()) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 10);
    end
  end

  // Offer one command item from the falling edge; hold it until the handshake,
  // then note it in the scoreboard. Leaves time at the next falling edge.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] val,
                           input logic [RIDX_W-1:0] idx);
    while (!quiet_now() && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - CMD_W - CHAR_W - RIDX_W){1'b0}}, idx, val, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, val, idx);
    accepted_cmds++;
    @(negedge clk);
  endtask

  // Draw a random command; values and indexes lean towards stored entries so that
  // deletes hit and reads land in range most of the time.
  task automatic pick_command(input cmd_mix_t mix, output logic [CMD_W-1:0] cmd,
                              output logic [CHAR_W-1:0] val, output logic [RIDX_W-1:0] idx);
    int r;
    int app_t, first_t, last_t, all_t, read_t;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin app_t = 75; first_t = 82; last_t = 88; all_t = 91; read_t = 98; end
      MIX_DRAIN: begin app_t = 15; first_t = 40; last_t = 65; all_t = 78; read_t = 95; end
      default:   begin app_t = 40; first_t = 55; last_t = 68; all_t = 75; read_t = 95; end
    endcase
    if (r < app_t) cmd = CMD_APPEND;
    else if (r < first_t) cmd = CMD_DEL_FIRST;
    else if (r < last_t) cmd = CMD_DEL_LAST;
    else if (r < all_t) cmd = CMD_DEL_ALL;
    else if (r < read_t) cmd = CMD_READ;
    else cmd = CMD_WIDTH_CAST($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));

    r = $urandom_range(0, 99);
    if (cmd != CMD_APPEND && sb.fill > 0 && r < 60) val = sb.chars[$urandom_range(0, sb.fill - 1)];
    else if (r < 80) val = CHAR_W'(8'h61 + $urandom_range(0, 3));   // small alphabet
    else val = CHAR_W'($urandom_range(0, 255));

    if (sb.fill > 0 && $urandom_range(0, 99) < 75) idx = RIDX_W'($urandom_range(0, sb.fill - 1));
    else idx = RIDX_W'($urandom_range(0, 63));
  endtask

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] val;
    logic [RIDX_W-1:0] idx;
    cmd_mix_t          mix;

    sb = new();
    sb.clear();
    accepted_cmds = 0;
    cycle_count   = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Deletes and read on an empty store, then the spare command codes
    send_item(CMD_DEL_FIRST, 8'h00, 6'd0);
    send_item(CMD_DEL_LAST,  8'hFF, 6'd63);
    send_item(CMD_DEL_ALL,   8'h5A, 6'd0);
    send_item(CMD_READ,      8'h00, 6'd0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_item(CMD_WIDTH_CAST(c), 8'hFF, 6'd63);

    // Build a short sequence with repeats and extreme characters
    send_item(CMD_APPEND, 8'h00, 6'd0);
    send_item(CMD_APPEND, 8'hFF, 6'd0);
    send_item(CMD_APPEND, 8'h55, 6'd0);
    send_item(CMD_APPEND, 8'hAA, 6'd0);
    send_item(CMD_APPEND, 8'hFF, 6'd0);
    send_item(CMD_APPEND, 8'h00, 6'd0);
    send_item(CMD_APPEND, 8'h55, 6'd0);

    // Reads at both ends, beyond the end and exactly at the length
    send_item(CMD_READ, 8'h00, 6'd0);
    send_item(CMD_READ, 8'h00, 6'd6);
    send_item(CMD_READ, 8'h00, 6'd63);
    send_item(CMD_READ, 8'h00, 6'd7);

    // First, last and every occurrence, plus values that are absent
    send_item(CMD_DEL_FIRST, 8'hFF, 6'd0);
    send_item(CMD_DEL_LAST,  8'h00, 6'd0);
    send_item(CMD_DEL_FIRST, 8'h77, 6'd0);
    send_item(CMD_DEL_ALL,   8'h55, 6'd0);
    send_item(CMD_DEL_LAST,  8'h12, 6'd0);
    send_item(CMD_READ,      8'h00, 6'd1);

    // Random part in runs of mixed length; fill runs push the store to full and beyond
    mix = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 59) == 0) mix = cmd_mix_t'($urandom_range(0, 2));
      pick_command(mix, cmd, val, idx);
      send_item(cmd, val, idx);
    end
    in_tvalid <= 1'b0;

    // Wait for the outstanding results, then give stray items a chance to show
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/csd_pkg.sv
rtl/csd_ram.sv
rtl/csd_dp.sv
rtl/csd_ctrl.sv
rtl/char_sequence_delete_by_value_core.sv
bench/char_sequence_delete_by_value_core_tb.sv
